// ===== hw/rtl/plmc_pkg.sv =====
// Package for the per-label mean color block: sizes, the item type and the
// store entry type. Used by every module of the block; depends on nothing.
`default_nettype none
package plmc_pkg;
    localparam int LABEL_BITS      = 16;
    localparam int MAX_PIXELS_LOG2 = 22;
    localparam int DEPTH           = 1 << LABEL_BITS;
    localparam int COLOR_W         = 8;
    localparam int CNT_W           = 23;
    localparam int SUM_W           = 30;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = 2;
    localparam logic [CNT_W-1:0] COUNT_BOUND = CNT_W'(64'd1 << MAX_PIXELS_LOG2);

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] label;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_item;

    typedef struct packed {
        logic [SUM_W-1:0] blue_sum;
        logic [SUM_W-1:0] green_sum;
        logic [SUM_W-1:0] red_sum;
        logic [CNT_W-1:0] count;
        logic             sat;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_qctl;
endpackage
`default_nettype wire

// ===== hw/rtl/plmc_front.sv =====
// Front part: takes requests into a short queue that the back part drains.
// Depends on plmc_pkg.
`default_nettype none
module plmc_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  plmc_pkg::t_item       i_item,
    input  wire                   i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output plmc_pkg::t_item       o_item
);
    plmc_pkg::t_item r_mem [plmc_pkg::QUEUE_DEPTH];
    logic [plmc_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [plmc_pkg::QPTR_W:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (plmc_pkg::QPTR_W+1)'(plmc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        else if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (plmc_pkg::QPTR_W+1)'(plmc_pkg::QUEUE_DEPTH)) else $error("queue count");
endmodule
`default_nettype wire

// ===== hw/rtl/plmc_div.sv =====
// Restoring divider giving an 8-bit quotient, one bit per cycle.
// Depends on plmc_pkg.
`default_nettype none
module plmc_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [plmc_pkg::SUM_W-1:0]    i_num,
    input  wire [plmc_pkg::CNT_W-1:0]    i_den,
    output logic                         o_done,
    output logic [plmc_pkg::COLOR_W-1:0] o_quot
);
    logic [plmc_pkg::SUM_W-1:0]   r_rem;
    logic [plmc_pkg::CNT_W-1:0]   r_den;
    logic [2:0]                   r_k;
    logic                         r_run;
    logic [plmc_pkg::SUM_W:0]     den_sh;
    logic                         take;

    // The quotient fits in 8 bits because each sum is below 256 times its count.
    assign den_sh = (plmc_pkg::SUM_W+1)'(r_den) << r_k;
    assign take   = ({1'b0, r_rem} >= den_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_rem <= i_num;
                r_den <= i_den;
                r_k   <= 3'd7;
            end else if (r_run) begin
                if (take) r_rem <= r_rem - den_sh[plmc_pkg::SUM_W-1:0];
                o_quot[r_k] <= take;
                r_k <= r_k - 1'b1;
                if (r_k == 3'd0) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/plmc_back.sv =====
// Back part: the per-label store, its clearing sweep and the sequencer that
// accumulates pixels and reads out means. Depends on plmc_pkg and plmc_div.
`default_nettype none
module plmc_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    input  plmc_pkg::t_item              i_q_item,
    output plmc_pkg::t_qctl              o_qctl,
    output logic                         o_clearing,
    output logic                         o_valid,
    output logic [7:0]                   o_mean_blue,
    output logic [7:0]                   o_mean_green,
    output logic [7:0]                   o_mean_red,
    output logic [22:0]                  o_pixel_total,
    output logic                         o_present,
    output logic                         o_overflow
);
    typedef enum logic [1:0] {S_CLR, S_IDLE, S_EXE, S_DIV} t_state;

    plmc_pkg::t_entry r_mem [plmc_pkg::DEPTH];
    plmc_pkg::t_entry r_rdata, r_entry, wdata;
    plmc_pkg::t_item  r_item;
    logic [plmc_pkg::LABEL_BITS-1:0] r_clr_addr, waddr;
    logic             we;
    t_state           r_state;
    logic [1:0]       r_col;
    logic [1:0]       sel;
    logic             div_start, div_done;
    logic [plmc_pkg::SUM_W-1:0] div_num;
    logic [7:0]       div_q;
    logic             pop;

    assign pop        = (r_state == S_IDLE) && i_q_valid;
    assign o_qctl     = '{valid: i_q_valid, pop: pop};
    assign o_clearing = (r_state == S_CLR);

    always_comb begin
        we    = 1'b0;
        waddr = r_item.label[plmc_pkg::LABEL_BITS-1:0];
        wdata = '0;
        if (r_state == S_CLR) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (r_state == S_EXE) begin
            we = 1'b1;
            if (r_item.op == plmc_pkg::OP_ACCUM) begin
                wdata = r_rdata;
                if (r_rdata.count >= plmc_pkg::COUNT_BOUND) begin
                    wdata.sat = 1'b1;
                end else begin
                    wdata.blue_sum  = r_rdata.blue_sum  + plmc_pkg::SUM_W'(r_item.blue);
                    wdata.green_sum = r_rdata.green_sum + plmc_pkg::SUM_W'(r_item.green);
                    wdata.red_sum   = r_rdata.red_sum   + plmc_pkg::SUM_W'(r_item.red);
                    wdata.count     = r_rdata.count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (pop) r_rdata <= r_mem[i_q_item.label[plmc_pkg::LABEL_BITS-1:0]];
    end

    assign sel = (r_state == S_EXE) ? 2'd0 : r_col + 1'b1;
    always_comb begin
        case (sel)
            2'd0:    div_num = r_rdata.blue_sum;
            2'd1:    div_num = r_entry.green_sum;
            default: div_num = r_entry.red_sum;
        endcase
    end
    assign div_start = ((r_state == S_EXE) && (r_item.op == plmc_pkg::OP_READ)) ||
                       ((r_state == S_DIV) && div_done && (r_col != 2'd2));

    plmc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   ((r_state == S_EXE) ? r_rdata.count : r_entry.count),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (pop) begin
                        r_item  <= i_q_item;
                        r_state <= S_EXE;
                    end
                end
                S_EXE: begin
                    if (r_item.op == plmc_pkg::OP_ACCUM) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_entry <= r_rdata;
                        r_col   <= 2'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_col <= r_col + 1'b1;
                        case (r_col)
                            2'd0:    o_mean_blue  <= r_entry.count != '0 ? div_q : 8'd0;
                            2'd1:    o_mean_green <= r_entry.count != '0 ? div_q : 8'd0;
                            default: o_mean_red   <= r_entry.count != '0 ? div_q : 8'd0;
                        endcase
                        if (r_col == 2'd2) begin
                            o_pixel_total <= r_entry.count;
                            o_present     <= (r_entry.count != '0);
                            o_overflow    <= r_entry.sat;
                            o_valid       <= 1'b1;
                            r_state       <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_valid) else $error("result during clear");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_state == S_EXE)) else $error("pop without execute");
    a_result_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(div_done)) else $error("result without divide");
endmodule
`default_nettype wire

// ===== hw/rtl/per_label_mean_color.sv =====
// Top level of the per-label mean color block: front queue plus back store.
// Depends on plmc_pkg, plmc_front, plmc_back.
//
//  channel   | handshake          | payload
//  request   | start / busy       | i_operation i_label i_blue i_green i_red
//  result    | o_valid (strobe)   | o_mean_* o_pixel_total o_present o_overflow
//
// An accumulate request passes through the store sequencer as a read, then a
// write back; a read request waits on the one shared divider, which produces
// the three means one bit per cycle in turn.
// After reset the store is cleared by a sweep over every entry, one entry a
// cycle, while busy stays high. A four-entry queue lets requests arrive while
// the sequencer works; busy is high when it is full. The receiver cannot stall:
// each result is shown for one cycle with o_valid.
`default_nettype none
module per_label_mean_color (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_operation,
    input  wire  [15:0] i_label,
    input  wire  [7:0]  i_blue,
    input  wire  [7:0]  i_green,
    input  wire  [7:0]  i_red,
    output logic        o_valid,
    output logic [7:0]  o_mean_blue,
    output logic [7:0]  o_mean_green,
    output logic [7:0]  o_mean_red,
    output logic [22:0] o_pixel_total,
    output logic        o_present,
    output logic        o_overflow
);
    plmc_pkg::t_item in_item, q_item;
    plmc_pkg::t_qctl qctl;
    logic            q_full, q_valid, clearing, push;

    // Requests are held off during the clearing sweep and while the queue is full.
    assign busy    = q_full || clearing;
    assign push    = start && !busy;
    assign in_item = '{op: plmc_pkg::t_op'(i_operation), label: i_label,
                       blue: i_blue, green: i_green, red: i_red};

    plmc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .i_pop   (qctl.pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    plmc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_qctl        (qctl),
        .o_clearing    (clearing),
        .o_valid       (o_valid),
        .o_mean_blue   (o_mean_blue),
        .o_mean_green  (o_mean_green),
        .o_mean_red    (o_mean_red),
        .o_pixel_total (o_pixel_total),
        .o_present     (o_present),
        .o_overflow    (o_overflow)
    );
endmodule
`default_nettype wire

// ===== dv/per_label_mean_color_checker.sv =====
// Checker for the per-label mean color block: watches requests and results,
// predicts each read result from its own copy of the label store, compares.
// Depends on plmc_pkg.
`timescale 1ns / 1ps
module per_label_mean_color_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire         i_operation,
    input  wire  [15:0] i_label,
    input  wire  [7:0]  i_blue,
    input  wire  [7:0]  i_green,
    input  wire  [7:0]  i_red,
    input  wire         o_valid,
    input  wire  [7:0]  o_mean_blue,
    input  wire  [7:0]  o_mean_green,
    input  wire  [7:0]  o_mean_red,
    input  wire  [22:0] o_pixel_total,
    input  wire         o_present,
    input  wire         o_overflow,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [7:0]  mean_blue;
        logic [7:0]  mean_green;
        logic [7:0]  mean_red;
        logic [22:0] pixel_total;
        logic        present;
        logic        overflow;
    } t_color_stats;

    // Sparse copy of the store; a missing key is an all-zero entry.
    longint unsigned blue_acc[int];
    longint unsigned green_acc[int];
    longint unsigned red_acc[int];
    longint unsigned pix_cnt[int];
    bit              sat_mark[int];
    t_color_stats    stats_due[$];

    function automatic logic [7:0] floor_mean(longint unsigned sum, longint unsigned n);
        if (n == 0) return 8'd0;
        return 8'(sum / n);
    endfunction

    function automatic t_color_stats read_and_clear(int slot);
        t_color_stats s;
        longint unsigned n;
        n = pix_cnt.exists(slot) ? pix_cnt[slot] : 0;
        s.mean_blue   = floor_mean(blue_acc.exists(slot) ? blue_acc[slot] : 0, n);
        s.mean_green  = floor_mean(green_acc.exists(slot) ? green_acc[slot] : 0, n);
        s.mean_red    = floor_mean(red_acc.exists(slot) ? red_acc[slot] : 0, n);
        s.pixel_total = 23'(n);
        s.present     = (n != 0);
        s.overflow    = sat_mark.exists(slot) ? sat_mark[slot] : 1'b0;
        blue_acc.delete(slot);
        green_acc.delete(slot);
        red_acc.delete(slot);
        pix_cnt.delete(slot);
        sat_mark.delete(slot);
        return s;
    endfunction

    function automatic void add_pixel(int slot, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        longint unsigned n;
        n = pix_cnt.exists(slot) ? pix_cnt[slot] : 0;
        if (n >= (64'd1 << plmc_pkg::MAX_PIXELS_LOG2)) begin
            sat_mark[slot] = 1'b1;
        end else begin
            blue_acc[slot]  = (blue_acc.exists(slot) ? blue_acc[slot] : 0) + b;
            green_acc[slot] = (green_acc.exists(slot) ? green_acc[slot] : 0) + g;
            red_acc[slot]   = (red_acc.exists(slot) ? red_acc[slot] : 0) + r;
            pix_cnt[slot]   = n + 1;
        end
    endfunction

    always @(posedge i_clk) begin
        int slot;
        t_color_stats want;
        t_color_stats got;
        if (!i_rst_n) begin
            blue_acc.delete();
            green_acc.delete();
            red_acc.delete();
            pix_cnt.delete();
            sat_mark.delete();
            stats_due.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (o_valid) begin
                got = '{o_mean_blue, o_mean_green, o_mean_red, o_pixel_total,
                        o_present, o_overflow};
                if (stats_due.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = stats_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (start && !busy) begin
                slot = int'(i_label & (plmc_pkg::DEPTH - 1));
                if (plmc_pkg::t_op'(i_operation) == plmc_pkg::OP_READ)
                    stats_due.push_back(read_and_clear(slot));
                else
                    add_pixel(slot, i_blue, i_green, i_red);
            end
            o_pending <= stats_due.size();
        end
    end
endmodule

// ===== dv/per_label_mean_color_tb.sv =====
// Testbench top for the per-label mean color block: clock, reset, request
// stimulus, watchdog and verdict. Depends on plmc_pkg, the block and the checker.
`timescale 1ns / 1ps
module per_label_mean_color_tb;
    // The clearing sweep after reset keeps busy high while it covers every store
    // entry, so the watchdog must tolerate that plus some margin.
    localparam int IDLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS = 1080;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_operation;
    logic [15:0] i_label;
    logic [7:0]  i_blue;
    logic [7:0]  i_green;
    logic [7:0]  i_red;
    logic        o_valid;
    logic [7:0]  o_mean_blue;
    logic [7:0]  o_mean_green;
    logic [7:0]  o_mean_red;
    logic [22:0] o_pixel_total;
    logic        o_present;
    logic        o_overflow;
    int          errors;
    int          pending;
    int          idle_cycles;
    bit          no_gaps;
    logic [15:0] label_pool[16];

    per_label_mean_color dut (.*);

    per_label_mean_color_checker checker_inst (
        .i_clk, .i_rst_n, .start, .busy, .i_operation, .i_label, .i_blue,
        .i_green, .i_red, .o_valid, .o_mean_blue, .o_mean_green, .o_mean_red,
        .o_pixel_total, .o_present, .o_overflow,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: any cycle that moves a request or a result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[per_label_mean_color] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one request. Called and returning at a falling edge. The gap is
    // drawn per request unless a back-to-back stretch is running; start is
    // held high across gapless requests so it never toggles within a step.
    task automatic send_request(plmc_pkg::t_op op, logic [15:0] label,
                                logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            start = 1'b0;
            i_operation = 1'($urandom);
            i_label = 16'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        start       = 1'b1;
        i_operation = op;
        i_label     = label;
        i_blue      = b;
        i_green     = g;
        i_red       = r;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        plmc_pkg::t_op op;
        logic [15:0]   label;
        int            pick;
        no_gaps     = 1'b0;
        start       = 1'b0;
        i_operation = plmc_pkg::OP_ACCUM;
        i_label     = '0;
        i_blue      = '0;
        i_green     = '0;
        i_red       = '0;
        i_rst_n     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: an empty read, label extremes, color extremes, a read
        // whose color fields carry junk, and a label reused after its read.
        send_request(plmc_pkg::OP_READ, 16'h1234, 8'hff, 8'hff, 8'hff);
        send_request(plmc_pkg::OP_ACCUM, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_request(plmc_pkg::OP_ACCUM, 16'h0000, 8'hff, 8'hff, 8'hff);
        send_request(plmc_pkg::OP_ACCUM, 16'h0000, 8'hff, 8'h00, 8'h80);
        send_request(plmc_pkg::OP_ACCUM, 16'hffff, 8'hff, 8'hff, 8'hff);
        send_request(plmc_pkg::OP_ACCUM, 16'hffff, 8'hff, 8'hff, 8'hfe);
        send_request(plmc_pkg::OP_ACCUM, 16'h5555, 8'h55, 8'haa, 8'h01);
        send_request(plmc_pkg::OP_ACCUM, 16'haaaa, 8'haa, 8'h55, 8'h80);
        send_request(plmc_pkg::OP_READ, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_request(plmc_pkg::OP_READ, 16'hffff, 8'haa, 8'h55, 8'hff);
        send_request(plmc_pkg::OP_READ, 16'h5555, 8'h00, 8'h00, 8'h00);
        send_request(plmc_pkg::OP_READ, 16'haaaa, 8'h00, 8'h00, 8'h00);
        send_request(plmc_pkg::OP_READ, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_request(plmc_pkg::OP_ACCUM, 16'hffff, 8'h07, 8'h08, 8'h09);
        send_request(plmc_pkg::OP_READ, 16'hffff, 8'h00, 8'h00, 8'h00);

        // Pause until every result is back before the random part.
        wait_drained();

        foreach (label_pool[k]) label_pool[k] = 16'($urandom);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Mix stretches with and without gaps, chosen at random.
            if (n % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_ITEMS / 2) wait_drained();
            pick = $urandom_range(0, 99);
            // Most traffic hits a small label pool so reads find real sums;
            // some goes to arbitrary labels to exercise every label bit.
            label = (pick < 85) ? label_pool[$urandom_range(0, 15)] : 16'($urandom);
            op = ($urandom_range(0, 99) < 15) ? plmc_pkg::OP_READ : plmc_pkg::OP_ACCUM;
            send_request(op, label, 8'($urandom), 8'($urandom), 8'($urandom));
        end

        // Read the whole pool back so every sum accumulated in the pool gets checked.
        foreach (label_pool[k])
            send_request(plmc_pkg::OP_READ, label_pool[k], 8'h00, 8'h00, 8'h00);

        wait_drained();
        repeat (64) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[per_label_mean_color] OK");
        end else begin
            $display("[per_label_mean_color] ERROR");
        end
        $finish;
    end
endmodule
